// ===== rtl/khs_pkg.sv =====
package khs_pkg;

   localparam int unsigned CrcW     = 16;
   localparam int unsigned SlotW    = 14;
   localparam int unsigned ByteW    = 8;
   localparam int unsigned QDepth   = 2;
   localparam int unsigned QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
   localparam int unsigned QCountW  = $clog2(QDepth + 1);

   localparam logic [CrcW-1:0]  CrcPoly    = 16'h1021;
   localparam logic [ByteW-1:0] OpenBrace  = 8'h7B;
   localparam logic [ByteW-1:0] CloseBrace = 8'h7D;

   typedef enum logic [1:0] {
      CLS_OTHER,
      CLS_OPEN,
      CLS_CLOSE
   } byte_class_type;

   typedef enum logic [2:0] {
      PH_SEARCH = 3'd0,
      PH_OPENED = 3'd1,
      PH_INSIDE = 3'd2,
      PH_TAGGED = 3'd3,
      PH_EMPTY  = 3'd4
   } tag_phase_type;

   typedef struct packed {
      logic [ByteW-1:0] key_byte;
      logic             present;
      logic             last;
      byte_class_type   cls;
   } khs_word_type;

   // queue side as seen by the front and by the back
   typedef struct packed {
      logic push;
      logic pop;
   } khs_q_ctrl_type;

   typedef struct packed {
      logic full;
      logic valid;
   } khs_q_stat_type;

   function automatic logic [CrcW-1:0] crc16_byte(input logic [CrcW-1:0]  crc,
                                                  input logic [ByteW-1:0] data);
      logic [CrcW-1:0] c;
      c = crc ^ {data, {(CrcW-ByteW){1'b0}}};
      for (int i = 0; i < ByteW; i++) begin
         c = c[CrcW-1] ? ({c[CrcW-2:0], 1'b0} ^ CrcPoly) : {c[CrcW-2:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// ===== rtl/key_hash_slot_crc16_unit.sv =====
// Key hash slot unit: CRC-16 (poly 0x1021, init 0) of a key, masked to 14 bits.
// Request channel (req_): one key byte per word; req_byte_present says the byte
// counts, req_last_byte ends the key. A word with neither is dropped.
// Response channel (rsp_): one word per key, rsp_slot and rsp_tag_used; when the
// first brace pair in the key encloses bytes, only those bytes are hashed.
// Both channels: a word moves on a clock edge with valid high and stall low.
// Throughput: one key byte per cycle, sustained while no final byte waits on
// rsp_stall; the rate is set by the single-byte CRC update in the back end.
// Path of a final word: input register, then the queue, then the result register
// that drives rsp_valid as the word leaves the queue; while the response side
// stalls, the final word waits in the queue.
// When rsp_stall holds the result, later non-final bytes still drain; the next
// final byte waits in the queue, and req_stall rises once the queue and the
// input register are full.
// Reset (synchronous) empties the queue, clears both CRCs and the brace state,
// and drops any pending response; req_stall is low afterwards.
module key_hash_slot_crc16_unit
   import khs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [ByteW-1:0] req_key_byte,
   input  logic             req_byte_present,
   input  logic             req_last_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [SlotW-1:0] rsp_slot,
   output logic             rsp_tag_used
);

   khs_q_ctrl_type q_ctrl;
   khs_q_stat_type q_stat;
   khs_word_type   push_word, head_word;
   logic           q_push, q_pop;

   assign q_ctrl.push = q_push;
   assign q_ctrl.pop  = q_pop;

   khs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_key_byte     (req_key_byte),
      .req_byte_present (req_byte_present),
      .req_last_byte    (req_last_byte),
      .q_stat           (q_stat),
      .q_push           (q_push),
      .q_word           (push_word)
   );

   khs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_ctrl  (q_ctrl),
      .wr_word (push_word),
      .q_stat  (q_stat),
      .rd_word (head_word)
   );

   khs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_stat       (q_stat),
      .q_word       (head_word),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_slot     (rsp_slot),
      .rsp_tag_used (rsp_tag_used)
   );

endmodule

// ===== rtl/khs_front.sv =====
module khs_front
   import khs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [ByteW-1:0] req_key_byte,
   input  logic             req_byte_present,
   input  logic             req_last_byte,
   input  khs_q_stat_type   q_stat,
   output logic             q_push,
   output khs_word_type     q_word
);

   logic           front_valid_ff, front_valid_in;
   khs_word_type   front_word_ff, front_word_in;
   byte_class_type cls;

   assign req_stall = front_valid_ff & q_stat.full;
   assign q_push    = front_valid_ff & ~q_stat.full;
   assign q_word    = front_word_ff;

   always_comb begin
      priority if (req_key_byte == OpenBrace) begin
         cls = CLS_OPEN;
      end else if (req_key_byte == CloseBrace) begin
         cls = CLS_CLOSE;
      end else begin
         cls = CLS_OTHER;
      end
   end

   // idle words (no byte, no end) are taken and dropped here
   always_comb begin
      front_valid_in = front_valid_ff;
      front_word_in  = front_word_ff;
      if (!req_stall) begin
         front_valid_in         = req_valid & (req_byte_present | req_last_byte);
         front_word_in.key_byte = req_key_byte;
         front_word_in.present  = req_byte_present;
         front_word_in.last     = req_last_byte;
         front_word_in.cls      = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_word_ff <= front_word_in;
   end

endmodule

// ===== rtl/khs_queue.sv =====
module khs_queue
   import khs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  khs_q_ctrl_type q_ctrl,
   input  khs_word_type   wr_word,
   output khs_q_stat_type q_stat,
   output khs_word_type   rd_word
);

   khs_word_type       mem_ff [QDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCountW-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign q_stat.full  = (count_ff == QCountW'(QDepth));
   assign q_stat.valid = (count_ff != '0);
   assign rd_word      = mem_ff[rd_ptr_ff];

   assign do_push = q_ctrl.push & ~q_stat.full;
   assign do_pop  = q_ctrl.pop & q_stat.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_word;
      end
   end

endmodule

// ===== rtl/khs_back.sv =====
module khs_back
   import khs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  khs_q_stat_type   q_stat,
   input  khs_word_type     q_word,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [SlotW-1:0] rsp_slot,
   output logic             rsp_tag_used
);

   tag_phase_type    phase_ff, phase_in, phase_upd;
   logic [CrcW-1:0]  whole_crc_ff, whole_crc_in, whole_upd;
   logic [CrcW-1:0]  tag_crc_ff, tag_crc_in, tag_upd;
   logic             tag_feed;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SlotW-1:0] rsp_slot_ff, rsp_slot_in;
   logic             rsp_tag_used_ff, rsp_tag_used_in;
   logic             out_free, take;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   // a word that ends no key never waits on the result side
   assign q_pop    = q_stat.valid & (~q_word.last | out_free);
   assign take     = q_pop;

   // brace tracker: next phase
   always_comb begin
      phase_upd = phase_ff;
      if (q_word.present) begin
         unique case (phase_ff)
            PH_SEARCH: begin
               if (q_word.cls == CLS_OPEN) begin
                  phase_upd = PH_OPENED;
               end
            end
            PH_OPENED: begin
               phase_upd = (q_word.cls == CLS_CLOSE) ? PH_EMPTY : PH_INSIDE;
            end
            PH_INSIDE: begin
               if (q_word.cls == CLS_CLOSE) begin
                  phase_upd = PH_TAGGED;
               end
            end
            default: begin
               phase_upd = phase_ff;
            end
         endcase
      end
   end

   // brace tracker: outputs
   always_comb begin
      unique case (phase_ff)
         PH_OPENED, PH_INSIDE: tag_feed = q_word.present & (q_word.cls != CLS_CLOSE);
         default:              tag_feed = 1'b0;
      endcase
   end

   assign whole_upd = q_word.present ? crc16_byte(whole_crc_ff, q_word.key_byte)
                                     : whole_crc_ff;
   assign tag_upd   = tag_feed ? crc16_byte(tag_crc_ff, q_word.key_byte) : tag_crc_ff;

   always_comb begin
      phase_in        = phase_ff;
      whole_crc_in    = whole_crc_ff;
      tag_crc_in      = tag_crc_ff;
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_slot_in     = rsp_slot_ff;
      rsp_tag_used_in = rsp_tag_used_ff;
      if (take) begin
         if (q_word.last) begin
            phase_in        = PH_SEARCH;
            whole_crc_in    = '0;
            tag_crc_in      = '0;
            rsp_valid_in    = 1'b1;
            rsp_tag_used_in = (phase_upd == PH_TAGGED);
            rsp_slot_in     = (phase_upd == PH_TAGGED) ? tag_upd[SlotW-1:0]
                                                       : whole_upd[SlotW-1:0];
         end else begin
            phase_in     = phase_upd;
            whole_crc_in = whole_upd;
            tag_crc_in   = tag_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SEARCH;
         whole_crc_ff <= '0;
         tag_crc_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         whole_crc_ff <= whole_crc_in;
         tag_crc_ff   <= tag_crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_slot_ff     <= rsp_slot_in;
      rsp_tag_used_ff <= rsp_tag_used_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_tag_used = rsp_tag_used_ff;

endmodule

// ===== rtl/khs_checker.sv =====
module khs_checker
   import khs_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic [ByteW-1:0] req_key_byte,
   input logic             req_byte_present,
   input logic             req_last_byte,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [SlotW-1:0] rsp_slot,
   input logic             rsp_tag_used
);

   // nothing survives a reset on either side
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response or stall left over after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_tag_used))
      else $error("stalled response word changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_key_byte)
                                 && $stable(req_byte_present) && $stable(req_last_byte))
      else $error("stalled request word changed");

   // a response needs at least the input register and queue behind it
   a_rsp_not_early: assert property (@(posedge clock)
      $rose(rsp_valid) |-> !$past(reset) && !$past(reset, 2))
      else $error("response appeared too soon after reset");

   // the front end only pushes back while the response side is stalled or was
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("request stall without a word taken before");

endmodule

bind key_hash_slot_crc16_unit khs_checker u_khs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_key_byte     (req_key_byte),
   .req_byte_present (req_byte_present),
   .req_last_byte    (req_last_byte),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_slot         (rsp_slot),
   .rsp_tag_used     (rsp_tag_used)
);
